### sv/sss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sss_pkg
// Shared types, register map and character folding for the substring search.
// ----------------------------------------------------------------------------
package sss_pkg;

  typedef logic [7:0] char_t;

  // Register slots on the config bus (8-byte stride, slot = paddr[5:3])
  typedef enum logic [2:0] {
    REG_PATTERN          = 3'd0,
    REG_PATTERN_LEN      = 3'd1,
    REG_START_OFFSET     = 3'd2,
    REG_CASE_INSENSITIVE = 3'd3,
    REG_SEARCH_BACKWARD  = 3'd4
  } reg_slot_t;

  localparam int unsigned ADDR_BITS     = 6;
  localparam int unsigned DATA_BITS     = 64;
  localparam int unsigned LEN_BITS      = 4;
  localparam int unsigned OFFSET_BITS   = 16;
  localparam int unsigned OUT_POS_BITS  = 16;

  localparam char_t ASCII_UPPER_A = 8'h41;
  localparam char_t ASCII_UPPER_Z = 8'h5A;
  localparam char_t ASCII_CASE    = 8'h20;

  // Fold A-Z to a-z when folding is enabled
  function automatic char_t fold_char(input char_t c, input logic fold_en);
    char_t r;
    r = c;
    if (fold_en && (c >= ASCII_UPPER_A) && (c <= ASCII_UPPER_Z)) begin
      r = c + ASCII_CASE;
    end
    return r;
  endfunction

endpackage

### sv/substring_search_stream.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// substring_search_stream
// Streaming pattern search over text bytes with first/last match reporting.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one text byte per request, with
//   in_last_byte marking the final byte of a text. A byte request is taken
//   every cycle; in_stall only rises when a finished result is still held
//   in the output register, the receiver stalls it, and the byte waiting in
//   the input register is the last byte of the next text.
//   Result channel (out_valid / out_stall): exactly one request per text,
//   issued for its last byte: out_found and out_match_position.
//   Configuration: APB-style port, 64-bit data, registers at paddr 8*i.
//   Write it only while no text is in flight.
// Throughput: 1 byte per cycle sustained while in_stall stays low. A last
//   byte goes from the input register through the window compare into the
//   result register; a result still held in the output register can stall
//   it in the input register. The compare of up to MAX_PATTERN bytes in
//   parallel sets the depth of the one combinational stage.
// Reset: clears the stream state, config registers and both valid flags.
// ----------------------------------------------------------------------------
module substring_search_stream #(
  parameter int unsigned MAX_PATTERN   = 8,
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // text input
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          in_text_byte,
  input  logic                                in_last_byte,
  // result output
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_found,
  output logic [sss_pkg::OUT_POS_BITS-1:0]    out_match_position,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sss_pkg::ADDR_BITS-1:0]       paddr,
  input  logic [sss_pkg::DATA_BITS-1:0]       pwdata,
  output logic [sss_pkg::DATA_BITS-1:0]       prdata,
  output logic                                pready
);

  // Counter saturates one bit above the position range so overflow is visible
  localparam int unsigned CW = POSITION_BITS + 1;
  localparam int unsigned SW = (POSITION_BITS > sss_pkg::OUT_POS_BITS) ?
                               POSITION_BITS : sss_pkg::OUT_POS_BITS;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [sss_pkg::DATA_BITS-1:0]   pattern_r;
  logic [sss_pkg::LEN_BITS-1:0]    pattern_len_r;
  logic [sss_pkg::OFFSET_BITS-1:0] start_offset_r;
  logic                            case_insensitive_r;
  logic                            search_backward_r;
  logic                            cfg_wr;
  sss_pkg::reg_slot_t              cfg_slot;

  assign pready   = 1'b1;
  assign cfg_wr   = psel & penable & pwrite & pready;
  assign cfg_slot = sss_pkg::reg_slot_t'(paddr[sss_pkg::ADDR_BITS-1:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r          <= '0;
      pattern_len_r      <= '0;
      start_offset_r     <= '0;
      case_insensitive_r <= 1'b0;
      search_backward_r  <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_slot)
        sss_pkg::REG_PATTERN:          pattern_r          <= pwdata;
        sss_pkg::REG_PATTERN_LEN:      pattern_len_r      <= pwdata[sss_pkg::LEN_BITS-1:0];
        sss_pkg::REG_START_OFFSET:     start_offset_r     <= pwdata[sss_pkg::OFFSET_BITS-1:0];
        sss_pkg::REG_CASE_INSENSITIVE: case_insensitive_r <= pwdata[0];
        sss_pkg::REG_SEARCH_BACKWARD:  search_backward_r  <= pwdata[0];
        default: ;  // unmapped slots: drop the write
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (cfg_slot)
      sss_pkg::REG_PATTERN:          prdata = pattern_r;
      sss_pkg::REG_PATTERN_LEN:      prdata = sss_pkg::DATA_BITS'(pattern_len_r);
      sss_pkg::REG_START_OFFSET:     prdata = sss_pkg::DATA_BITS'(start_offset_r);
      sss_pkg::REG_CASE_INSENSITIVE: prdata = sss_pkg::DATA_BITS'(case_insensitive_r);
      sss_pkg::REG_SEARCH_BACKWARD:  prdata = sss_pkg::DATA_BITS'(search_backward_r);
      default:                       prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Handshake and input register
  // --------------------------------------------------------------------------
  logic                  s1_valid_r, s1_valid_nxt;
  sss_pkg::char_t        s1_byte_r;
  logic                  s1_last_r;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_found_r;
  logic [sss_pkg::OUT_POS_BITS-1:0] out_pos_r;

  logic in_acc;
  logic out_free;
  logic s1_adv;
  logic s1_done_last;

  // Output register can take a result if empty or being drained this edge
  assign out_free     = !out_valid_r || !out_stall;
  // Non-last bytes always advance; a last byte needs room in the output reg
  assign s1_adv       = s1_valid_r && (!s1_last_r || out_free);
  assign s1_done_last = s1_adv && s1_last_r;
  assign in_stall     = s1_valid_r && !s1_adv;
  assign in_acc       = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_done_last) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the payload while stalled; load on every accepted request
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_text_byte;
      s1_last_r <= in_last_byte;
    end
  end

  // --------------------------------------------------------------------------
  // Stream state: window, byte count, recorded match
  // --------------------------------------------------------------------------
  sss_pkg::char_t          win_r   [MAX_PATTERN];
  sss_pkg::char_t          win_nxt [MAX_PATTERN];
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic                    seen_r, seen_nxt;
  logic [POSITION_BITS-1:0] best_r, best_nxt;

  logic [CW:0]              end_pos;
  logic [CW:0]              len_w;
  logic [CW:0]              start_w;
  logic [POSITION_BITS-1:0] start_lo;
  logic [SW-1:0]            start_cmp;
  logic [SW-1:0]            offset_cmp;
  logic [SW-1:0]            best_ext;
  logic                     len_ok;
  logic                     in_range;
  logic                     win_hit;
  logic                     hit;

  // Shift the new byte in at entry 0
  always_comb begin
    win_nxt[0] = s1_byte_r;
    for (int i = 1; i < MAX_PATTERN; i++) begin
      win_nxt[i] = win_r[i-1];
    end
  end

  assign end_pos  = {1'b0, cnt_r} + (CW+1)'(1);
  assign len_w    = (CW+1)'(pattern_len_r);
  assign start_w  = end_pos - len_w;
  assign start_lo = start_w[POSITION_BITS-1:0];
  assign len_ok   = (pattern_len_r != '0) &&
                    (pattern_len_r <= sss_pkg::LEN_BITS'(MAX_PATTERN)) &&
                    (end_pos >= len_w);
  // Ignore starts past the position range
  assign in_range = (start_w[CW:POSITION_BITS] == '0);
  assign start_cmp  = SW'(start_lo);
  assign offset_cmp = SW'(start_offset_r);

  // Pattern byte k lines up with window entry len-1-k
  always_comb begin
    logic [sss_pkg::LEN_BITS-1:0] tap;
    sss_pkg::char_t               t;
    sss_pkg::char_t               p;
    win_hit = 1'b1;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      tap = pattern_len_r - sss_pkg::LEN_BITS'(1) - sss_pkg::LEN_BITS'(k);
      t   = '0;
      for (int j = 0; j < MAX_PATTERN; j++) begin
        if (tap == sss_pkg::LEN_BITS'(j)) begin
          t = win_nxt[j];
        end
      end
      p = pattern_r[8*k +: 8];
      if ((sss_pkg::LEN_BITS'(k) < pattern_len_r) &&
          (sss_pkg::fold_char(p, case_insensitive_r) !=
           sss_pkg::fold_char(t, case_insensitive_r))) begin
        win_hit = 1'b0;
      end
    end
  end

  assign hit = len_ok && in_range && win_hit;

  // Record the match: backward keeps the latest at or before the start offset, forward keeps the first at or after it
  always_comb begin
    seen_nxt = seen_r;
    best_nxt = best_r;
    if (hit) begin
      if (search_backward_r) begin
        if (start_cmp <= offset_cmp) begin
          seen_nxt = 1'b1;
          best_nxt = start_lo;
        end
      end else if (!seen_r && (start_cmp >= offset_cmp)) begin
        seen_nxt = 1'b1;
        best_nxt = start_lo;
      end
    end
  end

  // Saturate the byte count
  assign cnt_nxt  = (&cnt_r) ? cnt_r : end_pos[CW-1:0];
  assign best_ext = SW'(best_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      seen_r <= 1'b0;
      best_r <= '0;
      for (int i = 0; i < MAX_PATTERN; i++) begin
        win_r[i] <= '0;
      end
    end else if (s1_adv) begin
      if (s1_last_r) begin
        // End of text: clear the stream state for the next one
        cnt_r  <= '0;
        seen_r <= 1'b0;
        best_r <= '0;
        for (int i = 0; i < MAX_PATTERN; i++) begin
          win_r[i] <= '0;
        end
      end else begin
        cnt_r  <= cnt_nxt;
        seen_r <= seen_nxt;
        best_r <= best_nxt;
        for (int i = 0; i < MAX_PATTERN; i++) begin
          win_r[i] <= win_nxt[i];
        end
      end
    end
  end

  // Result register: load on the last byte, hold while stalled
  always_ff @(posedge clk) begin
    if (s1_done_last) begin
      out_found_r <= seen_nxt;
      out_pos_r   <= seen_nxt ? best_ext[sss_pkg::OUT_POS_BITS-1:0] : '0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_found          = out_found_r;
  assign out_match_position = out_pos_r;

endmodule
